// ===== rtl/nle_pkg.sv =====
`default_nettype none

package nle_pkg;

   localparam int LINE_DEPTH = 64;
   localparam int ADDR_W     = $clog2(LINE_DEPTH);
   localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'd32;

   localparam logic [LEN_W-1:0] MAX_LINE_RESET = 7'd65;

   // register index taken from paddr[2]
   localparam logic REG_MAX_LINE_BYTES = 1'b0;

   typedef struct packed {
      logic [BYTE_W-1:0] line_byte;
      logic              last_of_line;
   } rsp_entry_type;

   typedef struct packed {
      logic [1:0] count;
      logic       pop;
   } buf_status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/nle_rsp_buf.sv =====
`default_nettype none

module nle_rsp_buf (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire nle_pkg::rsp_entry_type push_data,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output nle_pkg::rsp_entry_type     head,
   output nle_pkg::buf_status_type    status
);
   import nle_pkg::*;

   rsp_entry_type head_ff, head_in;
   rsp_entry_type spare_ff, spare_in;
   logic [1:0]    count_ff, count_in;
   logic          pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign head      = head_ff;
   assign status    = '{count: count_ff, pop: pop};

   always_comb begin
      head_in  = head_ff;
      spare_in = spare_ff;
      count_in = count_ff;
      if (push && pop) begin
         if (count_ff == 2'd2) begin
            head_in  = spare_ff;
            spare_in = push_data;
         end else begin
            head_in = push_data;
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            head_in = push_data;
         end else begin
            spare_in = push_data;
         end
         count_in = count_ff + 2'd1;
      end else if (pop) begin
         head_in  = spare_ff;
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      head_ff  <= head_in;
      spare_ff <= spare_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/newline_line_extractor.sv =====
`default_nettype none
// Newline line extractor.
// Input beats on req_* carry one received byte each. Leading spaces of a
// line are dropped; every other byte, the newline included, goes into a
// 64-entry line memory. At a newline the line is read back from memory and
// sent out on rsp_*, one beat per byte, the newline last with
// rsp_last_of_line set and rsp_line_length on every beat. A line longer
// than max_line_bytes - 1 bytes, or longer than the memory, is dropped.
// max_line_bytes is written through the APB port at byte address 0.
// Rate: req_ready is high while no line is being read out, so bytes are
// taken one per cycle. Between the accepting edge of a newline that emits
// a line and its first valid beat lie the state register, the memory read
// register and the 2-entry output buffer; the rest follow one per cycle
// while rsp_ready is high. Input is blocked until the buffer has drained.
// When rsp_ready is low, reads stop once the output buffer is full and
// resume when it drains; nothing is lost.
// Reset (synchronous) empties the line, clears the output buffer and sets
// max_line_bytes to 65. The memory contents are not cleared.
module newline_line_extractor (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [7:0]                        req_received_byte,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [7:0]                             rsp_line_byte,
   output logic                                   rsp_last_of_line,
   output logic [6:0]                             rsp_line_length,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [nle_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [nle_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [nle_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                   pready
);
   import nle_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             skip_ff, skip_in;
   logic             ovf_ff, ovf_in;
   logic [LEN_W-1:0] max_ff, max_in;
   logic [CNT_W-1:0] emit_len_ff, emit_len_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             rd_last_ff, rd_last_in;
   logic [BYTE_W-1:0] rd_data_ff;

   logic [BYTE_W-1:0] line_mem [LINE_DEPTH];

   logic             accept;
   logic             keep;
   logic             mem_we;
   logic             store_full;
   logic [CNT_W-1:0] count_nl;
   logic             ovf_nl;
   logic             fits;
   logic             rd_issue;
   logic [2:0]       occ_next;
   logic             csr_wr;

   rsp_entry_type    push_data;
   rsp_entry_type    head;
   buf_status_type   buf_status;

   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == REG_MAX_LINE_BYTES) ?
                      {{(CSR_DATA_W-LEN_W){1'b0}}, max_ff} : '0;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign keep      = accept && !(skip_ff && req_received_byte == CHAR_SPACE);
   assign store_full = (count_ff == CNT_W'(LINE_DEPTH));
   assign mem_we    = keep && !store_full;
   assign count_nl  = store_full ? count_ff : count_ff + CNT_W'(1);
   assign ovf_nl    = ovf_ff || store_full;
   assign fits      = ({1'b0, count_nl} + (CNT_W+1)'(1)) <= (CNT_W+1)'(max_ff);

   // buffer occupancy after this cycle plus the read about to be issued
   assign occ_next  = 3'(buf_status.count) + 3'(rd_pend_ff) + 3'd1 - 3'(buf_status.pop);
   assign rd_issue  = (state_ff == ST_EMIT) && (rd_idx_ff != emit_len_ff) &&
                      (occ_next <= 3'd2);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      skip_in     = skip_ff;
      ovf_in      = ovf_ff;
      max_in      = max_ff;
      emit_len_in = emit_len_ff;
      rd_idx_in   = rd_idx_ff;
      rd_pend_in  = rd_issue;
      rd_last_in  = rd_last_ff;

      if (csr_wr && paddr[2] == REG_MAX_LINE_BYTES) begin
         max_in = pwdata[LEN_W-1:0];
      end

      if (keep) begin
         skip_in  = 1'b0;
         count_in = count_nl;
         ovf_in   = ovf_nl;
         if (req_received_byte == CHAR_NEWLINE) begin
            count_in = '0;
            skip_in  = 1'b1;
            ovf_in   = 1'b0;
            if (!ovf_nl && fits) begin
               state_in    = ST_EMIT;
               emit_len_in = count_nl;
               rd_idx_in   = '0;
            end
         end
      end

      if (rd_issue) begin
         rd_idx_in  = rd_idx_ff + CNT_W'(1);
         rd_last_in = (rd_idx_ff + CNT_W'(1) == emit_len_ff);
      end

      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_EMIT: begin
            if (rd_idx_ff == emit_len_ff && !rd_pend_ff &&
                buf_status.count == 2'd0) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[count_ff[ADDR_W-1:0]] <= req_received_byte;
      end
      if (rd_issue) begin
         rd_data_ff <= line_mem[rd_idx_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      emit_len_ff <= emit_len_in;
      rd_idx_ff   <= rd_idx_in;
      rd_last_ff  <= rd_last_in;
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         skip_ff    <= 1'b1;
         ovf_ff     <= 1'b0;
         max_ff     <= MAX_LINE_RESET;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         skip_ff    <= skip_in;
         ovf_ff     <= ovf_in;
         max_ff     <= max_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   assign push_data = '{line_byte: rd_data_ff, last_of_line: rd_last_ff};

   nle_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (rd_pend_ff),
      .push_data (push_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .head      (head),
      .status    (buf_status)
   );

   assign rsp_line_byte    = head.line_byte;
   assign rsp_last_of_line = head.last_of_line;
   assign rsp_line_length  = LEN_W'(emit_len_ff);

   a_no_read_while_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rd_pend_ff && !rsp_valid)
      else $error("read or beat pending while input open");

   a_buf_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(rd_pend_ff && !buf_status.pop && buf_status.count == 2'd2))
      else $error("output buffer overrun");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(LINE_DEPTH))
      else $error("stored count beyond line depth");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line_length != '0 && rd_idx_ff <= emit_len_ff)
      else $error("bad line length during readout");

endmodule

`default_nettype wire

// ===== test/newline_line_extractor_test.sv =====
module newline_line_extractor_test;
   import nle_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] ADDR_MAX_LINE_BYTES = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_PAST_LAST_REG  = 3'd4;
   localparam int MAX_WAIT     = 17;
   localparam int DRAIN_CYCLES = LINE_DEPTH + 16;
   localparam int PRINT_CAP    = 40;

   typedef struct packed {
      logic [BYTE_W-1:0] ch;
      logic              last;
      logic [LEN_W-1:0]  len;
   } line_beat_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [BYTE_W-1:0]     req_received_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [BYTE_W-1:0]     rsp_line_byte;
   logic                  rsp_last_of_line;
   logic [LEN_W-1:0]      rsp_line_length;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // line framer model state
   logic [BYTE_W-1:0] line_mem [LINE_DEPTH];
   int                line_fill = 0;
   bit                at_line_start = 1'b1;
   bit                line_over = 1'b0;
   int                line_limit = int'(MAX_LINE_RESET);

   line_beat_type     line_beats [$];
   logic [BYTE_W-1:0] pending_bytes [$];

   bit send_steady = 1'b0;
   bit recv_steady = 1'b0;
   int gap_left = 0;
   int hold_left = 0;

   int fail_count = 0;
   int bytes_sent = 0;
   int beats_checked = 0;
   int lines_out = 0;
   int lines_dropped = 0;
   int csr_writes = 0;

   newline_line_extractor dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_received_byte (req_received_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_line_byte     (rsp_line_byte),
      .rsp_last_of_line  (rsp_last_of_line),
      .rsp_line_length   (rsp_line_length),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= PRINT_CAP) $display("%0t: %s", $time, what);
   endtask

   function automatic void take_received_byte(input logic [BYTE_W-1:0] b);
      line_beat_type beat;
      if (at_line_start && b == CHAR_SPACE) return;
      at_line_start = 1'b0;
      if (line_fill < LINE_DEPTH) begin
         line_mem[line_fill] = b;
         line_fill++;
      end else begin
         line_over = 1'b1;
      end
      if (b != CHAR_NEWLINE) return;
      if (!line_over && line_fill + 1 <= line_limit) begin
         for (int i = 0; i < line_fill; i++) begin
            beat.ch   = line_mem[i];
            beat.last = (i + 1 == line_fill);
            beat.len  = LEN_W'(line_fill);
            line_beats.push_back(beat);
         end
         lines_out++;
      end else begin
         lines_dropped++;
      end
      line_fill     = 0;
      at_line_start = 1'b1;
      line_over     = 1'b0;
   endfunction

   always @(posedge clock) begin : byte_feed
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            take_received_byte(req_received_byte);
            bytes_sent++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               req_valid         <= 1'b1;
               req_received_byte <= pending_bytes.pop_front();
               gap_left          <= send_steady ? 0 : $urandom_range(0, MAX_WAIT);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : beat_check
      line_beat_type want;
      int stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            beats_checked++;
            if (line_beats.size() == 0) begin
               report_mismatch($sformatf("beat %h with no line pending", rsp_line_byte));
            end else begin
               want = line_beats.pop_front();
               if (rsp_line_byte !== want.ch)
                  report_mismatch($sformatf("line_byte %h, want %h", rsp_line_byte, want.ch));
               if (rsp_last_of_line !== want.last)
                  report_mismatch($sformatf("last_of_line %b, want %b",
                                            rsp_last_of_line, want.last));
               if (rsp_line_length !== want.len)
                  report_mismatch($sformatf("line_length %0d, want %0d",
                                            rsp_line_length, want.len));
            end
            stall = recv_steady ? 0 : $urandom_range(0, MAX_WAIT);
            hold_left <= stall;
            rsp_ready <= (stall == 0);
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= (hold_left == 1);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data,
                             output logic [CSR_DATA_W-1:0] rd);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      while (!pready) @(negedge clock);
      rd = prdata;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic check_limit_readback();
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b0, ADDR_MAX_LINE_BYTES, '0, rd);
      if (rd[LEN_W-1:0] !== LEN_W'(line_limit))
         report_mismatch($sformatf("max_line_bytes reads %0d, want %0d",
                                   rd[LEN_W-1:0], line_limit));
   endtask

   task automatic set_line_limit(input int value);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b1, ADDR_MAX_LINE_BYTES,
                 ($urandom & 32'hFFFF_FF80) | CSR_DATA_W'(value & 'h7F), rd);
      line_limit = value & 'h7F;
      csr_writes++;
      check_limit_readback();
      @(negedge clock);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || line_beats.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
   endfunction

   // first body byte is never a space, so body + 1 is the line length
   function automatic void queue_random_line(input int lead, input int body);
      logic [BYTE_W-1:0] c;
      for (int i = 0; i < lead; i++) pending_bytes.push_back(CHAR_SPACE);
      for (int i = 0; i < body; i++) begin
         if (i != 0 && $urandom_range(0, 5) == 0) begin
            c = CHAR_SPACE;
         end else begin
            c = BYTE_W'($urandom_range(0, 255));
            if (c == CHAR_NEWLINE || c == CHAR_SPACE) c = ~c;
         end
         pending_bytes.push_back(c);
      end
      pending_bytes.push_back(CHAR_NEWLINE);
   endfunction

   task automatic random_phase(input int limit_value, input int byte_budget);
      int queued;
      int body;
      int lead;
      int pick;
      set_line_limit(limit_value);
      queued = 0;
      while (queued < byte_budget) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            body = $urandom_range(0, 10);
         end else if (pick < 9) begin
            body = line_limit - 3 + $urandom_range(0, 2);
            if (body < 0) body = 0;
            if (body > LINE_DEPTH + 2) body = LINE_DEPTH + 2;
         end else begin
            body = $urandom_range(LINE_DEPTH - 8, LINE_DEPTH + 6);
         end
         lead = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
         queue_random_line(lead, body);
         queued += lead + body + 1;
         if ($urandom_range(0, 7) == 0) send_steady = ~send_steady;
         if ($urandom_range(0, 7) == 0) recv_steady = ~recv_steady;
      end
      wait_idle();
   endtask

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] rd;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      check_limit_readback();
      @(negedge clock);

      // leading spaces, inner and trailing spaces, blank lines, byte extremes
      push_text("  A\n");
      push_text("B C \n");
      push_text("  \n");
      push_text("\n");
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(CHAR_SPACE);
      pending_bytes.push_back(8'hFF);
      pending_bytes.push_back(CHAR_NEWLINE);
      push_text("pq");
      wait_idle();

      // register index past the list must leave max_line_bytes alone
      csr_access(1'b1, ADDR_PAST_LAST_REG, $urandom, rd);
      check_limit_readback();

      // tightest buffer: only a bare newline fits; the held partial line is dropped
      set_line_limit(2);
      push_text("\n\na\n");
      wait_idle();

      set_line_limit(3);
      push_text("a\nab\n");
      wait_idle();

      send_steady = 1'b1;
      random_phase(65, 4);
      send_steady = 1'b0;
      random_phase(127, 4);
      recv_steady = 1'b1;
      random_phase(0, 4);
      random_phase($urandom_range(2, 65), 4);
      recv_steady = 1'b0;
      random_phase(64, 4);
      random_phase(1, 4);

      if (line_beats.size() != 0)
         report_mismatch($sformatf("%0d beats never arrived", line_beats.size()));
      $display("%0d bytes fed over %0d max_line_bytes settings", bytes_sent, csr_writes);
      $display("%0d lines sent (%0d beats checked), %0d lines dropped, %0d mismatches",
               lines_out, beats_checked, lines_dropped, fail_count);
      if (fail_count == 0) begin
         $display("newline_line_extractor_test: clean");
      end else begin
         $display("newline_line_extractor_test: errors");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("timeout with %0d beats outstanding", line_beats.size());
      $display("newline_line_extractor_test: errors");
      $finish;
   end

endmodule
